@@ design/rof_pkg.sv @@
// ============================================================================
// rof_pkg: shared definitions for the ring orientation filter
// Field widths, default parameter values and the vertex count limit used by
// the verdict.
// ============================================================================
`default_nettype none

package rof_pkg;

    // Width of the coordinate fields on the vertex channel.
    localparam int FIELD_W = 32;

    // Default parameter values for the top level.
    localparam int MAX_VERTICES_DEF = 65536;
    localparam int COORD_BITS_DEF   = 32;

    // A ring with this many vertices or fewer is never kept.
    localparam int FEW_LIMIT = 2;

endpackage

`default_nettype wire

@@ design/rof_if.sv @@
// ============================================================================
// rof_if: valid/ready channels of the ring orientation filter
// vertex_if carries one vertex per item, verdict_if one ring verdict per item.
// ============================================================================
`default_nettype none

interface vertex_if;
    import rof_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] vertex_x;
    logic signed [FIELD_W-1:0] vertex_y;
    logic                      ring_end;

    modport source (output valid, output vertex_x, output vertex_y, output ring_end,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input ring_end,
                    output ready);
endinterface

interface verdict_if;
    logic valid;
    logic ready;
    logic keep_ring;
    logic turn_positive;
    logic too_few_vertices;

    modport source (output valid, output keep_ring, output turn_positive,
                    output too_few_vertices, input ready);
    modport sink   (input valid, input keep_ring, input turn_positive,
                    input too_few_vertices, output ready);
endinterface

`default_nettype wire

@@ design/rof_tracker.sv @@
// ============================================================================
// rof_tracker: per-vertex tracking of the lowest vertex of a ring
// Keeps the first, previous and lowest vertex with its neighbors, and at ring
// end hands the three corner vertices and the size test to a job register.
// ============================================================================
`default_nettype none

module rof_tracker #(
    parameter int MAX_VERTICES = rof_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = rof_pkg::COORD_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [rof_pkg::FIELD_W-1:0] in_x,
    input  wire logic signed [rof_pkg::FIELD_W-1:0] in_y,
    input  wire logic                           in_end,
    output logic                                job_valid,
    input  wire logic                           job_ready,
    output logic signed [COORD_BITS-1:0]        job_low_x,
    output logic signed [COORD_BITS-1:0]        job_low_y,
    output logic signed [COORD_BITS-1:0]        job_pred_x,
    output logic signed [COORD_BITS-1:0]        job_pred_y,
    output logic signed [COORD_BITS-1:0]        job_succ_x,
    output logic signed [COORD_BITS-1:0]        job_succ_y,
    output logic                                job_few
);
    import rof_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic signed [CW-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic signed [CW-1:0] low_x_reg, low_y_reg, pred_x_reg, pred_y_reg;
    logic signed [CW-1:0] succ_x_reg, succ_y_reg;
    logic signed [CW-1:0] first_x_next, first_y_next, low_x_next, low_y_next;
    logic signed [CW-1:0] pred_x_next, pred_y_next, succ_x_next, succ_y_next;
    logic [CNT_W-1:0]     count_reg, count_next, count_sum;
    logic                 await_reg, await_next, await_upd;
    logic                 job_valid_reg;
    logic signed [CW-1:0] job_low_x_reg, job_low_y_reg, job_pred_x_reg, job_pred_y_reg;
    logic signed [CW-1:0] job_succ_x_reg, job_succ_y_reg;
    logic                 job_few_reg;
    logic signed [CW-1:0] x, y;
    logic                 accept;

    // Coordinates are taken at COORD_BITS and treated as signed.
    assign x = in_x[CW-1:0];
    assign y = in_y[CW-1:0];

    assign in_ready = !job_valid_reg || job_ready;
    assign accept   = in_valid && in_ready;

    // Next tracking state for the vertex on the input.
    always_comb
    begin
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        low_x_next   = low_x_reg;
        low_y_next   = low_y_reg;
        pred_x_next  = pred_x_reg;
        pred_y_next  = pred_y_reg;
        succ_x_next  = succ_x_reg;
        succ_y_next  = succ_y_reg;
        await_upd    = await_reg;
        if (count_reg == '0)
        begin
            first_x_next = x;
            first_y_next = y;
            low_x_next   = x;
            low_y_next   = y;
            await_upd    = 1'b1;
        end
        else
        begin
            if (await_reg)
            begin
                succ_x_next = x;
                succ_y_next = y;
                await_upd   = 1'b0;
            end
            if (y < low_y_reg)
            begin
                low_x_next  = x;
                low_y_next  = y;
                pred_x_next = prev_x_reg;
                pred_y_next = prev_y_reg;
                await_upd   = 1'b1;
            end
        end
        if (count_reg < CNT_W'(MAX_VERTICES))
            count_sum = count_reg + CNT_W'(1);
        else
            count_sum = count_reg;
        // A ring end starts a new ring.
        if (in_end)
        begin
            count_next = '0;
            await_next = 1'b0;
        end
        else
        begin
            count_next = count_sum;
            await_next = await_upd;
        end
    end

    // Tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            low_x_reg   <= '0;
            low_y_reg   <= '0;
            pred_x_reg  <= '0;
            pred_y_reg  <= '0;
            succ_x_reg  <= '0;
            succ_y_reg  <= '0;
            count_reg   <= '0;
            await_reg   <= 1'b0;
        end
        else if (accept)
        begin
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            prev_x_reg  <= x;
            prev_y_reg  <= y;
            low_x_reg   <= low_x_next;
            low_y_reg   <= low_y_next;
            pred_x_reg  <= pred_x_next;
            pred_y_reg  <= pred_y_next;
            succ_x_reg  <= succ_x_next;
            succ_y_reg  <= succ_y_next;
            count_reg   <= count_next;
            await_reg   <= await_next;
        end
    end

    // Job valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            job_valid_reg <= 1'b0;
        else if (accept && in_end)
            job_valid_reg <= 1'b1;
        else if (job_ready)
            job_valid_reg <= 1'b0;
    end

    // Corner vertices at ring end. When the lowest vertex is the first one its
    // predecessor is the last vertex; while it has no successor yet, the
    // successor is the first vertex.
    always_ff @(posedge clk)
    begin
        if (accept && in_end)
        begin
            job_low_x_reg <= low_x_next;
            job_low_y_reg <= low_y_next;
            if (low_y_next == first_y_next)
            begin
                job_pred_x_reg <= x;
                job_pred_y_reg <= y;
            end
            else
            begin
                job_pred_x_reg <= pred_x_next;
                job_pred_y_reg <= pred_y_next;
            end
            if (await_upd)
            begin
                job_succ_x_reg <= first_x_next;
                job_succ_y_reg <= first_y_next;
            end
            else
            begin
                job_succ_x_reg <= succ_x_next;
                job_succ_y_reg <= succ_y_next;
            end
            job_few_reg <= (count_sum <= CNT_W'(FEW_LIMIT));
        end
    end

    assign job_valid  = job_valid_reg;
    assign job_low_x  = job_low_x_reg;
    assign job_low_y  = job_low_y_reg;
    assign job_pred_x = job_pred_x_reg;
    assign job_pred_y = job_pred_y_reg;
    assign job_succ_x = job_succ_x_reg;
    assign job_succ_y = job_succ_y_reg;
    assign job_few    = job_few_reg;

endmodule

`default_nettype wire

@@ design/rof_cross.sv @@
// ============================================================================
// rof_cross: turn test at the lowest vertex
// Three register stages: edge differences, the two products, and the signed
// compare that forms the verdict held in the output register.
// ============================================================================
`default_nettype none

module rof_cross #(
    parameter int COORD_BITS = rof_pkg::COORD_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    job_valid,
    output logic                         job_ready,
    input  wire logic signed [COORD_BITS-1:0] job_low_x,
    input  wire logic signed [COORD_BITS-1:0] job_low_y,
    input  wire logic signed [COORD_BITS-1:0] job_pred_x,
    input  wire logic signed [COORD_BITS-1:0] job_pred_y,
    input  wire logic signed [COORD_BITS-1:0] job_succ_x,
    input  wire logic signed [COORD_BITS-1:0] job_succ_y,
    input  wire logic                    job_few,
    verdict_if.source                    verdict_out
);
    import rof_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    logic                 b_valid_reg, c_valid_reg, d_valid_reg;
    logic                 b_ready, c_ready, d_ready;
    logic signed [DW-1:0] b_dx1_reg, b_dy2_reg, b_dy1_reg, b_dx2_reg;
    logic                 b_few_reg, c_few_reg;
    logic signed [PW-1:0] c_p_reg, c_q_reg;
    logic signed [PW-1:0] dx1_w, dy2_w, dy1_w, dx2_w;
    logic                 d_keep_reg, d_turn_reg, d_few_reg;
    logic                 turn;

    // Stage readiness: a stage takes an item when empty or when it drains.
    assign d_ready   = !d_valid_reg || verdict_out.ready;
    assign c_ready   = !c_valid_reg || d_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign job_ready = b_ready;

    // Valid flags of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
                b_valid_reg <= job_valid;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
            if (d_ready)
                d_valid_reg <= c_valid_reg;
        end
    end

    // Edge differences: (low - pred) and (succ - low), one bit wider.
    always_ff @(posedge clk)
    begin
        if (b_ready && job_valid)
        begin
            b_dx1_reg <= DW'(job_low_x) - DW'(job_pred_x);
            b_dy1_reg <= DW'(job_low_y) - DW'(job_pred_y);
            b_dx2_reg <= DW'(job_succ_x) - DW'(job_low_x);
            b_dy2_reg <= DW'(job_succ_y) - DW'(job_low_y);
            b_few_reg <= job_few;
        end
    end

    assign dx1_w = PW'(b_dx1_reg);
    assign dy2_w = PW'(b_dy2_reg);
    assign dy1_w = PW'(b_dy1_reg);
    assign dx2_w = PW'(b_dx2_reg);

    // The two products of the cross product z, exact at full width.
    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_p_reg   <= dx1_w * dy2_w;
            c_q_reg   <= dy1_w * dx2_w;
            c_few_reg <= b_few_reg;
        end
    end

    assign turn = (c_p_reg > c_q_reg);

    // Verdict register.
    always_ff @(posedge clk)
    begin
        if (d_ready && c_valid_reg)
        begin
            d_turn_reg <= turn;
            d_few_reg  <= c_few_reg;
            d_keep_reg <= turn && !c_few_reg;
        end
    end

    assign verdict_out.valid            = d_valid_reg;
    assign verdict_out.keep_ring        = d_keep_reg;
    assign verdict_out.turn_positive    = d_turn_reg;
    assign verdict_out.too_few_vertices = d_few_reg;

endmodule

`default_nettype wire

@@ design/ring_orientation_filter_top.sv @@
// ============================================================================
// ring_orientation_filter_top: keep or drop polygon rings by orientation
// Streams ring vertices, finds the lowest vertex and its neighbors, and gives
// one verdict per ring from the sign of the cross product there.
// ============================================================================
//
// Channel       Dir  Item                                        Per
// vertex_in     in   vertex_x, vertex_y, ring_end               vertex
// verdict_out   out  keep_ring, turn_positive, too_few_vertices ring
//
// One vertex is taken every cycle while the input is not stalled; tracking
// compares and captures in the cycle that takes the vertex. A ring's result
// passes the job register (loaded on the edge that takes its last vertex),
// the difference stage and the product stage to the verdict register.
// Reset clears the tracking state and all stage valid flags; no clearing pass.
// A stalled verdict backs up the stages; once the job register is full and
// held, the vertex input stalls until it drains.
`default_nettype none

module ring_orientation_filter_top #(
    parameter int MAX_VERTICES = rof_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = rof_pkg::COORD_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    vertex_if.sink    vertex_in,
    verdict_if.source verdict_out
);
    import rof_pkg::*;

    logic                         job_valid, job_ready, job_few;
    logic signed [COORD_BITS-1:0] job_low_x, job_low_y, job_pred_x, job_pred_y;
    logic signed [COORD_BITS-1:0] job_succ_x, job_succ_y;

    // Per-vertex tracking.
    rof_tracker #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (vertex_in.valid),
        .in_ready   (vertex_in.ready),
        .in_x       (vertex_in.vertex_x),
        .in_y       (vertex_in.vertex_y),
        .in_end     (vertex_in.ring_end),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job_low_x  (job_low_x),
        .job_low_y  (job_low_y),
        .job_pred_x (job_pred_x),
        .job_pred_y (job_pred_y),
        .job_succ_x (job_succ_x),
        .job_succ_y (job_succ_y),
        .job_few    (job_few)
    );

    // Turn test and verdict.
    rof_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job_low_x   (job_low_x),
        .job_low_y   (job_low_y),
        .job_pred_x  (job_pred_x),
        .job_pred_y  (job_pred_y),
        .job_succ_x  (job_succ_x),
        .job_succ_y  (job_succ_y),
        .job_few     (job_few),
        .verdict_out (verdict_out)
    );

endmodule

`default_nettype wire
